@@ sv/sjf_pkg.sv @@
// shared types and constants of the sample jitter ring buffer
package sjf_pkg;

   // operation codes carried by an input item
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // fixed widths of the item fields
   localparam int unsigned OP_W     = 2;
   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned FILL_W   = 12;
   localparam int unsigned CSR_W    = 13;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RD   = 2'b10
   } sjf_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;       // an item is taken at this edge
      logic finish_read;  // memory read data is valid, complete the read item
   } sjf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_busy;     // a result is held and not taken this cycle
      logic item_is_read; // the offered item is a read
   } sjf_status_type;

endpackage

@@ sv/sjf_req_if.sv @@
// input item channel of the sample jitter ring buffer
interface sjf_req_if;
   logic                           valid;
   logic                           ready;
   logic [sjf_pkg::OP_W-1:0]       operation;
   logic [sjf_pkg::SAMPLE_W-1:0]   sample_in;

   modport source (output valid, output operation, output sample_in, input ready);
   modport sink   (input valid, input operation, input sample_in, output ready);
endinterface

@@ sv/sjf_rsp_if.sv @@
// result item channel of the sample jitter ring buffer
interface sjf_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sjf_pkg::SAMPLE_W-1:0]   sample_out;
   logic                           had_data;
   logic                           overflow_dropped;
   logic [sjf_pkg::FILL_W-1:0]     fill_level;

   modport source (output valid, output sample_out, output had_data,
                   output overflow_dropped, output fill_level, input ready);
   modport sink   (input valid, input sample_out, input had_data,
                   input overflow_dropped, input fill_level, output ready);
endinterface

@@ sv/sjf_ram.sv @@
// generic simple dual port ram with registered read
module sjf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sjf_ctrl.sv @@
// controller state machine: item acceptance and read sequencing
module sjf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  sjf_pkg::sjf_status_type status,
   output sjf_pkg::sjf_cmd_type    cmd
);

   sjf_pkg::sjf_state_type state_ff, state_in;

   // handshake and commands
   always_comb begin
      req_ready        = 1'b0;
      cmd.accept       = 1'b0;
      cmd.finish_read  = 1'b0;
      state_in         = state_ff;
      case (state_ff)
         sjf_pkg::ST_IDLE: begin
            req_ready  = !status.out_busy;
            cmd.accept = req_valid && !status.out_busy;
            if (cmd.accept && status.item_is_read) begin
               state_in = sjf_pkg::ST_RD;
            end
         end
         sjf_pkg::ST_RD: begin
            cmd.finish_read = 1'b1;
            state_in        = sjf_pkg::ST_IDLE;
         end
         default: begin
            state_in = sjf_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sjf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a read item enters the read wait state and leaves it for idle in the next cycle
   a_read_enters_rd: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.item_is_read) |=> (state_ff == sjf_pkg::ST_RD))
      else $error("read item did not enter the read wait state");

   a_rd_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sjf_pkg::ST_RD) |=> (state_ff == sjf_pkg::ST_IDLE))
      else $error("read wait state lasted more than one cycle");

endmodule

@@ sv/sjf_dpath.sv @@
// datapath: ring pointers, size register, sample memory and result register
module sjf_dpath #(
   parameter int unsigned MAX_SLOTS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sjf_pkg::sjf_cmd_type            cmd,
   output sjf_pkg::sjf_status_type         status,
   input  logic [sjf_pkg::OP_W-1:0]        operation,
   input  logic [sjf_pkg::SAMPLE_W-1:0]    sample_in,
   input  logic                            csr_write_en,
   input  logic [sjf_pkg::CSR_W-1:0]       csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sjf_pkg::SAMPLE_W-1:0]    sample_out,
   output logic                            had_data,
   output logic                            overflow_dropped,
   output logic [sjf_pkg::FILL_W-1:0]      fill_level
);

   localparam int unsigned PTR_W      = $clog2(MAX_SLOTS);
   localparam int unsigned SIZE_W     = $clog2(MAX_SLOTS + 1);
   localparam int unsigned SUM_W      = PTR_W + 1;
   localparam int unsigned RESET_SIZE = (MAX_SLOTS < 4096) ? MAX_SLOTS : 4096;

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [SIZE_W-1:0] size_ff, size_in;

   logic                          out_valid_ff, out_valid_in;
   logic [sjf_pkg::SAMPLE_W-1:0]  out_sample_ff, out_sample_in;
   logic                          out_had_ff, out_had_in;
   logic                          out_drop_ff, out_drop_in;
   logic [sjf_pkg::FILL_W-1:0]    out_fill_ff, out_fill_in;

   logic [SUM_W-1:0]  size_x;
   logic [SUM_W-1:0]  head_inc;
   logic [SUM_W-1:0]  tail_inc;
   logic [SUM_W-1:0]  tail_half;
   logic [PTR_W-1:0]  head_wrap;
   logic [PTR_W-1:0]  tail_wrap;
   logic [PTR_W-1:0]  tail_drop;
   logic [SUM_W-1:0]  fill_sum;
   logic [31:0]       fill_32;
   logic [31:0]       csr_32;
   logic [31:0]       clamp_32;
   logic              not_empty;
   logic              ram_we;
   logic              ram_re;
   logic [sjf_pkg::SAMPLE_W-1:0] ram_rdata;

   // pointer increments wrapped at the size in use
   always_comb begin
      size_x    = SUM_W'(size_ff);
      head_inc  = SUM_W'(head_ff) + SUM_W'(1);
      tail_inc  = SUM_W'(tail_ff) + SUM_W'(1);
      tail_half = SUM_W'(tail_ff) + SUM_W'(size_ff >> 1);
      head_wrap = (head_inc >= size_x) ? '0 : head_inc[PTR_W-1:0];
      tail_wrap = (tail_inc >= size_x) ? '0 : tail_inc[PTR_W-1:0];
      tail_drop = (tail_half >= size_x) ? PTR_W'(tail_half - size_x)
                                        : tail_half[PTR_W-1:0];
      not_empty = (head_ff != tail_ff);
   end

   // size register write value: zero becomes one, saturate at the ring depth
   always_comb begin
      csr_32 = 32'(csr_write_data);
      if (csr_32 == 32'd0) begin
         clamp_32 = 32'd1;
      end else if (csr_32 > 32'(MAX_SLOTS)) begin
         clamp_32 = 32'(MAX_SLOTS);
      end else begin
         clamp_32 = csr_32;
      end
   end

   // operation decode and next pointer values
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      size_in     = size_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      out_had_in  = 1'b0;
      out_drop_in = 1'b0;
      if (csr_write_en) begin
         size_in = SIZE_W'(clamp_32);
         head_in = '0;
         tail_in = '0;
      end else if (cmd.accept) begin
         case (operation)
            sjf_pkg::OP_WRITE: begin
               ram_we  = 1'b1;
               head_in = head_wrap;
               if (head_wrap == tail_ff) begin
                  tail_in     = tail_drop;
                  out_drop_in = 1'b1;
               end
            end
            sjf_pkg::OP_READ: begin
               if (not_empty) begin
                  ram_re     = 1'b1;
                  out_had_in = 1'b1;
                  tail_in    = tail_wrap;
               end
            end
            sjf_pkg::OP_CLEAR: begin
               head_in = '0;
               tail_in = '0;
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
   end

   // fill level after the operation
   always_comb begin
      if (head_in >= tail_in) begin
         fill_sum = SUM_W'(head_in) - SUM_W'(tail_in);
      end else begin
         fill_sum = SUM_W'(head_in) + size_x - SUM_W'(tail_in);
      end
      fill_32     = 32'(fill_sum);
      out_fill_in = fill_32[sjf_pkg::FILL_W-1:0];
   end

   // result register: read results wait for the registered memory data
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_sample_in = out_sample_ff;
      if (cmd.accept) begin
         out_valid_in  = (operation != sjf_pkg::OP_READ);
         out_sample_in = '0;
      end else if (cmd.finish_read) begin
         out_valid_in  = 1'b1;
         out_sample_in = out_had_ff ? ram_rdata : '0;
      end else if (rsp_ready) begin
         out_valid_in  = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         size_ff      <= SIZE_W'(RESET_SIZE);
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         size_ff      <= size_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload registers
   always_ff @(posedge clock) begin
      out_sample_ff <= out_sample_in;
      if (cmd.accept) begin
         out_had_ff  <= out_had_in;
         out_drop_ff <= out_drop_in;
         out_fill_ff <= out_fill_in;
      end
   end

   // sample memory
   sjf_ram #(
      .WIDTH (sjf_pkg::SAMPLE_W),
      .DEPTH (MAX_SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_ff),
      .wr_data (sample_in),
      .rd_en   (ram_re),
      .rd_addr (tail_ff),
      .rd_data (ram_rdata)
   );

   // status and result outputs
   assign status.out_busy     = out_valid_ff && !rsp_ready;
   assign status.item_is_read = (operation == sjf_pkg::OP_READ);
   assign rsp_valid           = out_valid_ff;
   assign sample_out          = out_sample_ff;
   assign had_data            = out_had_ff;
   assign overflow_dropped    = out_drop_ff;
   assign fill_level          = out_fill_ff;

   a_head_in_ring: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(head_ff) < SUM_W'(size_ff))
      else $error("head pointer outside the ring");

   a_tail_in_ring: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(tail_ff) < SUM_W'(size_ff))
      else $error("tail pointer outside the ring");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && (operation == sjf_pkg::OP_CLEAR))
         |=> ((head_ff == '0) && (tail_ff == '0)))
      else $error("clear did not zero the pointers");

endmodule

@@ sv/sample_jitter_fifo_drop_half.sv @@
// Top level of the sample jitter ring buffer.
// req_chan carries one item: an operation (write, read, clear) and a 32-bit
// sample word. rsp_chan returns one result per item: the sample read, a flag
// that the read found data, a flag that a write dropped the oldest half of
// the ring, and the fill level after the operation.
// csr_write_en with csr_write_data sets the ring size (zero becomes one,
// values above MAX_SLOTS saturate) and clears both pointers.
// A write, clear or no-op item gives its result in the cycle after it is
// taken; a read item goes through the registered memory read and then the
// result register. Writes and clears may follow each other every cycle
// while results are taken; a read holds off the input in the read wait state.
// A result register parts the channels: a new item is taken while a result
// is still shown as long as the receiver takes that result in the same
// cycle; while the receiver stalls, the input is held off.
// Reset clears the pointers and sets the size to MAX_SLOTS (at most 4096).
// Memory contents are not cleared; a slot is only read after a write.
module sample_jitter_fifo_drop_half #(
   parameter int unsigned MAX_SLOTS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   sjf_req_if.sink                      req_chan,
   sjf_rsp_if.source                    rsp_chan,
   input  logic                         csr_write_en,
   input  logic [sjf_pkg::CSR_W-1:0]    csr_write_data
);

   sjf_pkg::sjf_cmd_type    cmd;
   sjf_pkg::sjf_status_type status;

   // controller
   sjf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   sjf_dpath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .operation        (req_chan.operation),
      .sample_in        (req_chan.sample_in),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .sample_out       (rsp_chan.sample_out),
      .had_data         (rsp_chan.had_data),
      .overflow_dropped (rsp_chan.overflow_dropped),
      .fill_level       (rsp_chan.fill_level)
   );

endmodule
